/* hdl/tkr_pkg.sv */
// Shared types and constants for the timed key replay sequencer.
// Used by the action table module and the top level; depends on nothing.
`timescale 1ns / 1ps

package tkr_pkg;

  localparam int TableDepthDefault = 64;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_SCAN     = 2'd0,
    REQ_ACTIVATE = 2'd1,
    REQ_WRITE    = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_type_t;

  // Key state codes on the result channel.
  localparam logic KEY_HELD     = 1'b0;
  localparam logic KEY_RELEASED = 1'b1;

  typedef struct packed {
    logic [15:0] delay_ms;
    logic [15:0] press_ms;
    logic [7:0]  col;
    logic [7:0]  row;
  } entry_t;

  // Write request from the sequencer to the action table.
  typedef struct packed {
    logic       en;
    logic [5:0] index;
    entry_t     entry;
  } table_wr_t;

endpackage

/* hdl/tkr_table.sv */
// Action table: single write port, one registered read port with write bypass.
// Depends on tkr_pkg for the entry and write request types.
`timescale 1ns / 1ps

module tkr_table #(
  parameter int TABLE_DEPTH = tkr_pkg::TableDepthDefault,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  tkr_pkg::table_wr_t wr,
  input  logic [AW-1:0]      rd_addr,
  output tkr_pkg::entry_t    rd_data
);

  tkr_pkg::entry_t mem [TABLE_DEPTH];
  tkr_pkg::entry_t rd_data_r;

  logic [AW+5:0] wr_wide;
  logic [AW-1:0] wr_addr;
  logic          wr_ok;

  assign wr_wide = {{AW{1'b0}}, wr.index};
  assign wr_addr = wr_wide[AW-1:0];
  assign wr_ok   = wr.en && (wr_wide < (AW+6)'(TABLE_DEPTH));

  // A write to the slot being read lands in the read register at once, so the
  // read data always matches the table contents at the current position.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.entry;
    end
    if (wr_ok && (wr_addr == rd_addr)) begin
      rd_data_r <= wr.entry;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/timed_key_replay_sequencer_top.sv */
// Top level of the timed key replay sequencer: control state, timing and
// result register with skid stage. Depends on tkr_pkg and tkr_table.
`timescale 1ns / 1ps

// Usage
// Input beats carry a request kind on in_tuser: scan tick, activate playback
// or write of a table entry. Table writes and activates never give a result.
// A scan tick during playback gives at most one key event on the out_ channel:
// held while the press time has not passed, released on the tick it passes.
// Throughput is one input beat per clock cycle while the skid register is
// empty; each beat is handled in the cycle it is accepted and any result is
// registered in the output register, or in the skid register while the output
// beat is stalled. The position's table entry is read from a registered memory
// port addressed by the next position. When the receiver stalls, one further
// result is kept in a skid register; in_tready is low exactly while that skid
// register is occupied, and no beat is taken then, not even one that would
// give no result.
// Reset (rst_n low, synchronous) stops playback and clears position and
// timers. The action table is not cleared: entries are undefined until
// written, and there is no clearing pass.

module timed_key_replay_sequencer_top #(
  parameter int TABLE_DEPTH = tkr_pkg::TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] now_ms, [37:32] entry_index, [45:38] entry_row, [53:46] entry_col,
  // [69:54] entry_press_ms, [85:70] entry_delay_ms, [87:86] zero
  input  logic [87:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] key_row, [15:8] key_col, [16] key_state, [23:17] zero
  output logic [23:0] out_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);

  // Input field unpacking.
  logic [31:0]         now_ms;
  tkr_pkg::req_type_t  req;
  tkr_pkg::table_wr_t  wr;
  tkr_pkg::entry_t     cur_entry;

  assign now_ms            = in_tdata[31:0];
  assign req               = tkr_pkg::req_type_t'(in_tuser);
  assign wr.index          = in_tdata[37:32];
  assign wr.entry.row      = in_tdata[45:38];
  assign wr.entry.col      = in_tdata[53:46];
  assign wr.entry.press_ms = in_tdata[69:54];
  assign wr.entry.delay_ms = in_tdata[85:70];

  logic accept;
  assign accept = in_tvalid && in_tready;
  assign wr.en  = accept && (req == tkr_pkg::REQ_WRITE);

  // Control state.
  logic          playing_r, playing_nxt;
  logic          key_down_r, key_down_nxt;
  logic [PW-1:0] position_r, position_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [15:0]   hold_r, hold_nxt;
  logic [15:0]   gap_r, gap_nxt;

  // Result registers.
  logic        out_valid_r, skid_valid_r;
  logic [16:0] out_data_r, skid_data_r;
  logic        res_valid;
  logic [16:0] res_data;

  logic          in_range;
  logic [31:0]   elapsed;
  logic          hold_passed, gap_passed;
  logic [PW-1:0] rd_pos;

  assign in_range    = position_r < PW'(TABLE_DEPTH);
  assign elapsed     = now_ms - start_r;
  assign hold_passed = elapsed > {16'd0, hold_r};
  assign gap_passed  = elapsed > {16'd0, gap_r};
  // During reset the read port follows the first entry, where position restarts.
  assign rd_pos      = rst_n ? position_nxt : '0;

  tkr_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_pos[AW-1:0]),
    .rd_data (cur_entry)
  );

  always_comb begin
    playing_nxt  = playing_r;
    key_down_nxt = key_down_r;
    position_nxt = position_r;
    start_nxt    = start_r;
    hold_nxt     = hold_r;
    gap_nxt      = gap_r;
    res_valid    = 1'b0;
    res_data     = {1'b0, in_range ? cur_entry.col : 8'd0, in_range ? cur_entry.row : 8'd0};
    if (accept) begin
      case (req)
        tkr_pkg::REQ_ACTIVATE: begin
          playing_nxt = 1'b1;
        end
        tkr_pkg::REQ_SCAN: begin
          if (playing_r) begin
            if (hold_r == 16'd0) begin
              // Load tick: a position past the table end acts as a terminator.
              hold_nxt = in_range ? cur_entry.press_ms : 16'd0;
              gap_nxt  = in_range ? cur_entry.delay_ms : 16'd0;
              if (hold_nxt == 16'd0) begin
                position_nxt = '0;
                playing_nxt  = 1'b0;
              end else begin
                key_down_nxt = 1'b1;
                start_nxt    = now_ms;
              end
            end else if (key_down_r) begin
              res_valid = 1'b1;
              if (hold_passed) begin
                key_down_nxt = 1'b0;
                start_nxt    = now_ms;
                res_data[16] = tkr_pkg::KEY_RELEASED;
              end else begin
                res_data[16] = tkr_pkg::KEY_HELD;
              end
            end else if (gap_passed) begin
              if (in_range) begin
                position_nxt = position_r + PW'(1);
              end
              hold_nxt = 16'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r  <= 1'b0;
      key_down_r <= 1'b0;
      position_r <= '0;
      start_r    <= 32'd0;
      hold_r     <= 16'd0;
      gap_r      <= 16'd0;
    end else begin
      playing_r  <= playing_nxt;
      key_down_r <= key_down_nxt;
      position_r <= position_nxt;
      start_r    <= start_nxt;
      hold_r     <= hold_nxt;
      gap_r      <= gap_nxt;
    end
  end

  // Output register with a skid stage behind it. The skid register only fills
  // when a result arrives while the output beat is stalled.
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (res_valid) begin
      skid_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output register is empty");

  a_stop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(playing_r) |-> (position_r == '0) && (hold_r == 16'd0))
    else $error("playback stopped without returning to the first entry");

  a_press_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    key_down_r |-> (hold_r != 16'd0))
    else $error("key held with no press time loaded");

  a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= PW'(TABLE_DEPTH))
    else $error("position ran past the table end");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for timed_key_replay_sequencer_top: drives table
// writes, activates and scan ticks, predicts the key events and checks them.
// Depends on tkr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;

  localparam int Depth      = tkr_pkg::TableDepthDefault;
  localparam int CycleLimit = 200000;
  localparam int BeatTarget = 1450;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       state;
  } key_event_t;

  // Tracks the sequencer state and holds the key events still owed by the block.
  class key_replay_scoreboard;
    tkr_pkg::entry_t slots[Depth];
    bit          playing;
    bit          key_down;
    int unsigned position;
    bit [31:0]   phase_start;
    bit [15:0]   hold_ms;
    bit [15:0]   gap_ms;
    key_event_t  pending_events[$];
    int          mismatches;
    int          held_seen;
    int          released_seen;

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Wrap-safe: the elapsed time is taken modulo 2^32 and must exceed the limit.
    function bit timed_out(bit [31:0] now, bit [15:0] limit);
      bit [31:0] elapsed;
      elapsed = now - phase_start;
      return elapsed > {16'h0, limit};
    endfunction

    function key_event_t current_key(logic state);
      key_event_t ev;
      ev.row   = '0;
      ev.col   = '0;
      ev.state = state;
      if (position < Depth) begin
        ev.row = slots[position].row;
        ev.col = slots[position].col;
      end
      return ev;
    endfunction

    function void step_playback(bit [31:0] now);
      if (hold_ms == 0) begin
        if (position < Depth) begin
          hold_ms = slots[position].press_ms;
          gap_ms  = slots[position].delay_ms;
        end else begin
          // Running off the end of the table ends the sequence.
          hold_ms = '0;
          gap_ms  = '0;
        end
        if (hold_ms == 0) begin
          position = 0;
          playing  = 1'b0;
        end else begin
          key_down    = 1'b1;
          phase_start = now;
        end
      end else if (key_down) begin
        if (timed_out(now, hold_ms)) begin
          key_down    = 1'b0;
          phase_start = now;
          pending_events.push_back(current_key(tkr_pkg::KEY_RELEASED));
        end else begin
          pending_events.push_back(current_key(tkr_pkg::KEY_HELD));
        end
      end else if (timed_out(now, gap_ms)) begin
        if (position < Depth) position++;
        hold_ms = '0;
      end
    endfunction

    function void note_beat(tkr_pkg::req_type_t req, logic [87:0] data);
      case (req)
        tkr_pkg::REQ_ACTIVATE: playing = 1'b1;
        tkr_pkg::REQ_WRITE: begin
          if (data[37:32] < Depth) slots[data[37:32]] = tkr_pkg::entry_t'(data[85:38]);
        end
        tkr_pkg::REQ_SCAN: begin
          if (playing) step_playback(data[31:0]);
        end
        default: ;
      endcase
    endfunction

    task check_event(logic [23:0] data);
      key_event_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("key event %h with none outstanding", data));
        return;
      end
      want = pending_events.pop_front();
      if (data[7:0] != want.row)
        report_mismatch($sformatf("key_row %h, wanted %h", data[7:0], want.row));
      if (data[15:8] != want.col)
        report_mismatch($sformatf("key_col %h, wanted %h", data[15:8], want.col));
      if (data[16] != want.state)
        report_mismatch($sformatf("key_state %b, wanted %b", data[16], want.state));
      if (want.state == tkr_pkg::KEY_RELEASED) released_seen++;
      else held_seen++;
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // [31:0] now_ms, [37:32] entry_index, [45:38] entry_row, [53:46] entry_col,
  // [69:54] entry_press_ms, [85:70] entry_delay_ms, [87:86] zero
  logic [87:0] in_tdata   = '0;
  // [1:0] req_type
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] key_row, [15:8] key_col, [16] key_state, [23:17] zero
  logic [23:0] out_tdata;

  key_replay_scoreboard board = new();

  int        cycle_count   = 0;
  int        stall_left    = 0;
  bit        long_hold_req = 1'b0;
  bit        idle_on       = 1'b1;
  int        beats_sent    = 0;
  int        sequences     = 0;
  bit [31:0] clock_ms      = '0;

  timed_key_replay_sequencer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d key events outstanding.",
               board.pending_events.size());
      $display("** timed_key_replay_sequencer_top: FAILED **");
      $finish;
    end
  end

  // Result side: check each accepted beat, then decide the ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_event(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left    = 120;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task send_beat(tkr_pkg::req_type_t req, logic [31:0] now, logic [5:0] idx,
                 logic [7:0] row, logic [7:0] col, logic [15:0] press,
                 logic [15:0] delay);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, delay, press, col, row, idx, now};
    do @(posedge clk); while (!in_tready);
    board.note_beat(req, in_tdata);
    beats_sent++;
  endtask

  // Scan ticks carry junk in the entry fields, which the block must ignore.
  task scan_tick(bit [31:0] step);
    clock_ms = clock_ms + step;
    send_beat(tkr_pkg::REQ_SCAN, clock_ms, 6'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task write_slot(int idx, logic [7:0] row, logic [7:0] col, logic [15:0] press,
                  logic [15:0] delay);
    send_beat(tkr_pkg::REQ_WRITE, $urandom, 6'(idx), row, col, press, delay);
  endtask

  task activate();
    send_beat(tkr_pkg::REQ_ACTIVATE, $urandom, 6'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task noise_beat();
    case ($urandom_range(0, 3))
      0: write_slot($urandom_range(0, Depth - 1), 8'($urandom), 8'($urandom),
                    16'($urandom), 16'($urandom));
      1: activate();
      2: send_beat(tkr_pkg::REQ_UNUSED, $urandom, 6'($urandom), 8'($urandom),
                   8'($urandom), 16'($urandom), 16'($urandom));
      default: begin
        clock_ms = $urandom;
        scan_tick(0);
      end
    endcase
  endtask

  // Ticks until playback stops; after a while time jumps past any timeout so
  // that every sequence ends within a few hundred beats.
  task run_playback(bit with_noise);
    int ticks;
    ticks = 0;
    while (board.playing) begin
      ticks++;
      if (with_noise && $urandom_range(0, 11) == 0) noise_beat();
      else if (ticks > 150) scan_tick(70000);
      else if ($urandom_range(0, 19) == 0) scan_tick($urandom_range(0, 70000));
      else scan_tick($urandom_range(0, 3));
    end
  endtask

  task play_sequence();
    int n;
    int press_max;
    int delay_max;
    n         = ($urandom_range(0, 9) == 0) ? $urandom_range(7, Depth) : $urandom_range(1, 5);
    press_max = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 6);
    delay_max = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
      1, 2: clock_ms = $urandom;
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) noise_beat();
      write_slot(i, 8'($urandom), 8'($urandom), 16'($urandom_range(1, press_max)),
                 16'($urandom_range(0, delay_max)));
    end
    if (n < Depth) write_slot(n, 8'($urandom), 8'($urandom), 16'h0000, 16'($urandom));
    activate();
    run_playback(1'b1);
    repeat ($urandom_range(0, 2)) scan_tick($urandom_range(0, 3));
    sequences++;
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_events.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Every slot is written first, so no tick ever reads an unwritten entry.
    // Short presses without a terminator make this first run go off the table end.
    for (int i = 0; i < Depth; i++) write_slot(i, 8'($urandom), 8'($urandom), 16'd1, 16'd0);
    activate();
    run_playback(1'b0);

    // Directed beats: idle tick, unused kind, extreme entries, double activate,
    // a write during the press, exact timeout boundaries across the 32-bit wrap.
    scan_tick(0);
    send_beat(tkr_pkg::REQ_UNUSED, '1, '1, '1, '1, '1, '1);
    write_slot(0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    write_slot(1, 8'h00, 8'h00, 16'h0000, 16'h0000);
    write_slot(Depth - 1, 8'h00, 8'h00, 16'h0001, 16'h0000);
    activate();
    activate();
    clock_ms = 32'hFFFF_FFF0;
    scan_tick(0);
    scan_tick(1);
    write_slot(0, 8'h5A, 8'hA5, 16'hFFFF, 16'hFFFF);
    scan_tick(65534);
    scan_tick(1);
    scan_tick(65535);
    scan_tick(1);
    scan_tick(0);
    scan_tick(0);

    // Receiver holds off while a long press keeps producing held events.
    write_slot(0, 8'($urandom), 8'($urandom), 16'hFFFF, 16'h0000);
    write_slot(1, 8'($urandom), 8'($urandom), 16'h0000, 16'h0000);
    activate();
    long_hold_req = 1'b1;
    repeat (40) scan_tick(1);
    run_playback(1'b0);
    wait_drained();

    while (beats_sent < BeatTarget) begin
      idle_on = (beats_sent <= 1250) && ($urandom_range(0, 3) != 0);
      play_sequence();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    idle_on = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    if (board.pending_events.size() != 0)
      board.report_mismatch($sformatf("%0d key events never arrived",
                                      board.pending_events.size()));
    $display("Sent %0d beats over %0d replay sequences, table end and time wrap included.",
             beats_sent, sequences);
    $display("Checked %0d held and %0d released key events; %0d mismatches.",
             board.held_seen, board.released_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("** timed_key_replay_sequencer_top: PASSED **");
    end else begin
      $display("** timed_key_replay_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule
